/* sv/hlcd_pkg.sv */
// shared types, constants and the init strobe table of the lcd write sequencer
package hlcd_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned InitLen       = 12;
  localparam int unsigned StepW         = 4;

  localparam logic [12:0] NibWait     = 13'd50;
  localparam logic [12:0] ByteWait    = 13'd100;
  localparam logic [12:0] ClearWait   = 13'd2100;
  localparam logic [12:0] WakeWait    = 13'd5050;
  localparam logic [15:0] PowerupWait = 16'd50000;

  localparam logic [3:0] WakeNib   = 4'h3;
  localparam logic [3:0] FourBitNib = 4'h2;
  localparam logic [7:0] FuncSet   = 8'h28;
  localparam logic [7:0] DispOn    = 8'h0C;
  localparam logic [7:0] EntryMode = 8'h06;
  localparam logic [7:0] ClearCmd  = 8'h01;
  localparam logic [7:0] SetDdram  = 8'h80;

  localparam logic [6:0] Row1Reset = 7'h00;
  localparam logic [6:0] Row2Reset = 7'h40;
  localparam logic [6:0] Row3Reset = 7'h14;
  localparam logic [6:0] Row4Reset = 7'h54;

  typedef enum logic [2:0] {
    CmdInit   = 3'd0,
    CmdByte   = 3'd1,
    CmdChar   = 3'd2,
    CmdCursor = 3'd3,
    CmdClear  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    Row1 = 3'd1,
    Row2 = 3'd2,
    Row3 = 3'd3,
    Row4 = 3'd4
  } row_e;

  typedef enum logic [1:0] {
    RegRow1 = 2'd0,
    RegRow2 = 2'd1,
    RegRow3 = 2'd2,
    RegRow4 = 2'd3
  } reg_idx_e;

  // one queued job: either the whole init run or a single byte
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    logic       long_wait;
  } job_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;
  } strobe_t;

  function automatic strobe_t init_strobe(input logic [StepW-1:0] step);
    strobe_t s;
    s = '0;
    unique case (step)
      4'd0: begin
        s.nibble = WakeNib; s.wait_before_us = PowerupWait; s.wait_after_us = WakeWait;
      end
      4'd1, 4'd2: begin
        s.nibble = WakeNib; s.wait_after_us = WakeWait;
      end
      4'd3:  begin s.nibble = FourBitNib;     s.wait_after_us = NibWait;  end
      4'd4:  begin s.nibble = FuncSet[7:4];   s.wait_after_us = NibWait;  end
      4'd5:  begin s.nibble = FuncSet[3:0];   s.wait_after_us = ByteWait; end
      4'd6:  begin s.nibble = DispOn[7:4];    s.wait_after_us = NibWait;  end
      4'd7:  begin s.nibble = DispOn[3:0];    s.wait_after_us = ByteWait; end
      4'd8:  begin s.nibble = EntryMode[7:4]; s.wait_after_us = NibWait;  end
      4'd9:  begin s.nibble = EntryMode[3:0]; s.wait_after_us = ByteWait; end
      4'd10: begin s.nibble = ClearCmd[7:4];  s.wait_after_us = NibWait;  end
      4'd11: begin
        s.nibble = ClearCmd[3:0]; s.wait_after_us = ClearWait; s.last = 1'b1;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

/* sv/hlcd_if.sv */
// request and strobe channel interfaces
interface hlcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_byte;
  logic [2:0] row;
  logic [6:0] column;

  modport source (output valid, cmd, data_byte, row, column, input ready);
  modport sink (input valid, cmd, data_byte, row, column, output ready);
endinterface

interface hlcd_stb_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] wait_before_us;
  logic [12:0] wait_after_us;
  logic        last;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink (input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                output ready);
endinterface

/* sv/hlcd_front.sv */
// request decode: row base registers, cursor address and job classification
module hlcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  hlcd_req_if.sink         req,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [6:0]       cfg_data_i,
  input  logic             full_i,
  output logic             push_o,
  output hlcd_pkg::job_t   job_o
);

  logic [6:0] row1_q, row2_q, row3_q, row4_q;
  logic [6:0] base;
  logic [7:0] addr;
  logic       known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row1_q <= hlcd_pkg::Row1Reset;
      row2_q <= hlcd_pkg::Row2Reset;
      row3_q <= hlcd_pkg::Row3Reset;
      row4_q <= hlcd_pkg::Row4Reset;
    end else if (cfg_we_i) begin
      unique case (hlcd_pkg::reg_idx_e'(cfg_idx_i))
        hlcd_pkg::RegRow1: row1_q <= cfg_data_i;
        hlcd_pkg::RegRow2: row2_q <= cfg_data_i;
        hlcd_pkg::RegRow3: row3_q <= cfg_data_i;
        hlcd_pkg::RegRow4: row4_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    known = 1'b1;
    unique case (hlcd_pkg::row_e'(req.row))
      hlcd_pkg::Row1: base = row1_q;
      hlcd_pkg::Row2: base = row2_q;
      hlcd_pkg::Row3: base = row3_q;
      hlcd_pkg::Row4: base = row4_q;
      default: begin
        base  = '0;
        known = 1'b0;
      end
    endcase
    addr = known ? ({1'b0, base} + {1'b0, req.column}) : 8'd0;
  end

  assign req.ready = !full_i;

  // unknown request kinds are taken and dropped
  always_comb begin
    job_o  = '0;
    push_o = 1'b0;
    unique case (hlcd_pkg::cmd_e'(req.cmd))
      hlcd_pkg::CmdInit: begin
        job_o.is_init = 1'b1;
        push_o        = 1'b1;
      end
      hlcd_pkg::CmdByte: begin
        job_o.data = req.data_byte;
        push_o     = 1'b1;
      end
      hlcd_pkg::CmdChar: begin
        job_o.rs   = 1'b1;
        job_o.data = req.data_byte;
        push_o     = 1'b1;
      end
      hlcd_pkg::CmdCursor: begin
        job_o.data = hlcd_pkg::SetDdram | addr;
        push_o     = 1'b1;
      end
      hlcd_pkg::CmdClear: begin
        job_o.data      = hlcd_pkg::ClearCmd;
        job_o.long_wait = 1'b1;
        push_o          = 1'b1;
      end
      default: push_o = 1'b0;
    endcase
    push_o = push_o && req.valid && !full_i;
  end

endmodule

/* sv/hlcd_fifo.sv */
// short job queue between decode and strobe sequencer
module hlcd_fifo #(
  parameter int unsigned Depth = hlcd_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hlcd_pkg::job_t job_i,
  input  logic           pop_i,
  output hlcd_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hlcd_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count past depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

/* sv/hlcd_back.sv */
// strobe sequencer: head job to output register, one nibble per cycle unless stalled
module hlcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hlcd_pkg::job_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  hlcd_stb_if.source     stb
);

  logic [hlcd_pkg::StepW-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  hlcd_pkg::strobe_t          out_q, strobe;
  logic                       step_last, load, advance;

  always_comb begin
    if (head_i.is_init) begin
      strobe    = hlcd_pkg::init_strobe(step_q);
      step_last = (step_q == hlcd_pkg::StepW'(hlcd_pkg::InitLen - 1));
    end else begin
      strobe            = '0;
      strobe.reg_select = head_i.rs;
      step_last         = (step_q != '0);
      if (step_last) begin
        // low nibble carries the settle time of the whole byte
        strobe.nibble        = head_i.data[3:0];
        strobe.wait_after_us = head_i.long_wait ? hlcd_pkg::ClearWait : hlcd_pkg::ByteWait;
        strobe.last          = 1'b1;
      end else begin
        strobe.nibble        = head_i.data[7:4];
        strobe.wait_after_us = hlcd_pkg::NibWait;
      end
    end
    load        = !out_valid_q || stb.ready;
    advance     = !empty_i && load;
    pop_o       = advance && step_last;
    step_d      = advance ? (step_last ? '0 : step_q + 1'b1) : step_q;
    out_valid_d = load ? !empty_i : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= strobe;
    end
  end

  assign stb.valid          = out_valid_q;
  assign stb.reg_select     = out_q.reg_select;
  assign stb.nibble         = out_q.nibble;
  assign stb.wait_before_us = out_q.wait_before_us;
  assign stb.wait_after_us  = out_q.wait_after_us;
  assign stb.last           = out_q.last;

  a_byte_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !head_i.is_init) |-> step_q <= hlcd_pkg::StepW'(1))
    else $error("byte job step out of range");
  a_powerup_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.wait_before_us != '0) |->
      (out_q.nibble == hlcd_pkg::WakeNib && !out_q.reg_select && !out_q.last))
    else $error("power-up wait on wrong strobe");
  a_char_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.reg_select) |->
      (out_q.wait_after_us == hlcd_pkg::NibWait || out_q.wait_after_us == hlcd_pkg::ByteWait))
    else $error("character strobe with instruction timing");
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |=> ($past(step_q) == step_q)) else $error("step moved with no job");

endmodule

/* sv/char_lcd_4bit_write_sequencer.sv */
// top level of the 4-bit character lcd write sequencer
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   cmd, data_byte, row, column
//   stb_o    out  valid/ready   reg_select, nibble, wait_before_us, wait_after_us, last
//   cfg      in   cfg_we_i      cfg_idx_i (row base 1..4), cfg_data_i
//
// one strobe per cycle leaves unless stalled: init gives 12 strobes, other requests 2,
// unknown kinds none; a job passes the job queue, its strobes the output register
// requests are taken while the job queue has room, so the queue depth sets how far
// decode runs ahead of a stalled strobe sink
// reset clears the queue and the output register and loads the default row bases
module char_lcd_4bit_write_sequencer #(
  parameter int unsigned QueueDepth = hlcd_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hlcd_req_if.sink   req_i,
  hlcd_stb_if.source stb_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  hlcd_pkg::job_t job, head;
  logic           push, pop, empty, full;

  hlcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job)
  );

  hlcd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  hlcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .stb     (stb_o)
  );

endmodule

/* tb/char_lcd_4bit_write_sequencer_tb.sv */
// testbench for the 4-bit character lcd write sequencer: directed and random requests
`timescale 1ns / 1ps

module char_lcd_4bit_write_sequencer_tb;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned ResetCycles = 3;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned DrainLimit = 20000;
  localparam int unsigned HoldOffCycles = 80;
  localparam longint unsigned TimeoutNs = 20_000_000;
  localparam logic [2:0] CmdUnknownLo = 3'd5;
  localparam logic [2:0] CmdUnknownHi = 3'd7;
  localparam logic [6:0] BaseMax = 7'd127;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [6:0] cfg_data_i;

  hlcd_req_if req_if ();
  hlcd_stb_if stb_if ();

  char_lcd_4bit_write_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .stb_o      (stb_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state: copy of the row base registers and the strobes still owed
  logic [6:0]         row_base [4];
  hlcd_pkg::strobe_t  pending_strobes [$];
  int unsigned        error_count;
  int unsigned        requests_sent;
  int unsigned        strobes_checked;
  int unsigned        config_writes;
  bit                 sender_gaps_on;
  bit                 sink_stalls_on;
  int unsigned        sink_holdoff;

  always begin
    clk_i = 1'b1;
    #(HalfPeriod);
    clk_i = 1'b0;
    #(HalfPeriod);
  end

  function automatic void push_strobe(input logic rs, input logic [3:0] nib,
                                      input logic [15:0] before_us,
                                      input logic [12:0] after_us, input logic is_last);
    hlcd_pkg::strobe_t s;
    s.reg_select     = rs;
    s.nibble         = nib;
    s.wait_before_us = before_us;
    s.wait_after_us  = after_us;
    s.last           = is_last;
    pending_strobes.push_back(s);
  endfunction

  // high nibble first, the low nibble carries the settle time of the byte
  function automatic void push_byte(input logic rs, input logic [7:0] b,
                                    input logic [12:0] low_after, input logic is_last);
    push_strobe(rs, b[7:4], 16'd0, hlcd_pkg::NibWait, 1'b0);
    push_strobe(rs, b[3:0], 16'd0, low_after, is_last);
  endfunction

  function automatic void predict_strobes(input logic [2:0] cmd, input logic [7:0] data_byte,
                                          input logic [2:0] row, input logic [6:0] column);
    logic [7:0] addr;
    case (cmd)
      hlcd_pkg::CmdInit: begin
        push_strobe(1'b0, hlcd_pkg::WakeNib, hlcd_pkg::PowerupWait, hlcd_pkg::WakeWait, 1'b0);
        push_strobe(1'b0, hlcd_pkg::WakeNib, 16'd0, hlcd_pkg::WakeWait, 1'b0);
        push_strobe(1'b0, hlcd_pkg::WakeNib, 16'd0, hlcd_pkg::WakeWait, 1'b0);
        push_strobe(1'b0, hlcd_pkg::FourBitNib, 16'd0, hlcd_pkg::NibWait, 1'b0);
        push_byte(1'b0, hlcd_pkg::FuncSet, hlcd_pkg::ByteWait, 1'b0);
        push_byte(1'b0, hlcd_pkg::DispOn, hlcd_pkg::ByteWait, 1'b0);
        push_byte(1'b0, hlcd_pkg::EntryMode, hlcd_pkg::ByteWait, 1'b0);
        push_byte(1'b0, hlcd_pkg::ClearCmd, hlcd_pkg::ClearWait, 1'b1);
      end
      hlcd_pkg::CmdByte: push_byte(1'b0, data_byte, hlcd_pkg::ByteWait, 1'b1);
      hlcd_pkg::CmdChar: push_byte(1'b1, data_byte, hlcd_pkg::ByteWait, 1'b1);
      hlcd_pkg::CmdCursor: begin
        case (row)
          hlcd_pkg::Row1: addr = {1'b0, row_base[hlcd_pkg::RegRow1]} + {1'b0, column};
          hlcd_pkg::Row2: addr = {1'b0, row_base[hlcd_pkg::RegRow2]} + {1'b0, column};
          hlcd_pkg::Row3: addr = {1'b0, row_base[hlcd_pkg::RegRow3]} + {1'b0, column};
          hlcd_pkg::Row4: addr = {1'b0, row_base[hlcd_pkg::RegRow4]} + {1'b0, column};
          default:        addr = 8'd0;
        endcase
        push_byte(1'b0, hlcd_pkg::SetDdram | addr, hlcd_pkg::ByteWait, 1'b1);
      end
      hlcd_pkg::CmdClear: push_byte(1'b0, hlcd_pkg::ClearCmd, hlcd_pkg::ClearWait, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // strobe checker
  always @(posedge clk_i) begin
    hlcd_pkg::strobe_t want;
    if (rst_ni && stb_if.valid && stb_if.ready) begin
      if (pending_strobes.size() == 0) begin
        $display("%0t ns: unexpected strobe: expected none actual nibble %0h", $time,
                 stb_if.nibble);
        error_count++;
      end else begin
        want = pending_strobes.pop_front();
        check_field("reg_select", want.reg_select, stb_if.reg_select);
        check_field("nibble", want.nibble, stb_if.nibble);
        check_field("wait_before_us", want.wait_before_us, stb_if.wait_before_us);
        check_field("wait_after_us", want.wait_after_us, stb_if.wait_after_us);
        check_field("last", want.last, stb_if.last);
        strobes_checked++;
      end
    end
  end

  // strobe sink: random stall bursts, or one long hold-off on request
  initial begin
    stb_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_holdoff != 0) begin
        stb_if.ready = 1'b0;
        repeat (sink_holdoff) @(negedge clk_i);
        sink_holdoff = 0;
      end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
        stb_if.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      stb_if.ready = 1'b1;
    end
  end

  initial begin
    #(TimeoutNs);
    $display("char_lcd_4bit_write_sequencer: mismatch");
    $finish;
  end

  task automatic send_request(input logic [2:0] cmd, input logic [7:0] data_byte,
                              input logic [2:0] row, input logic [6:0] column);
    int unsigned gap;
    gap = 0;
    @(negedge clk_i);
    if (sender_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.cmd       = cmd;
    req_if.data_byte = data_byte;
    req_if.row       = row;
    req_if.column    = column;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_strobes(cmd, data_byte, row, column);
    requests_sent++;
  endtask

  task automatic send_random_request(output bit counted);
    int unsigned pick;
    logic [2:0]  cmd;
    logic [2:0]  row;
    pick = $urandom_range(0, 99);
    if (pick < 5) cmd = hlcd_pkg::CmdInit;
    else if (pick < 25) cmd = hlcd_pkg::CmdByte;
    else if (pick < 55) cmd = hlcd_pkg::CmdChar;
    else if (pick < 85) cmd = hlcd_pkg::CmdCursor;
    else if (pick < 92) cmd = hlcd_pkg::CmdClear;
    else cmd = 3'($urandom_range(CmdUnknownHi, CmdUnknownLo));
    // mostly valid rows so that the row bases get exercised
    if ($urandom_range(0, 99) < 85) row = 3'($urandom_range(hlcd_pkg::Row4, hlcd_pkg::Row1));
    else row = 3'($urandom_range(0, 7));
    send_request(cmd, 8'($urandom_range(0, 255)), row, 7'($urandom_range(0, 127)));
    counted = (cmd <= hlcd_pkg::CmdClear);
  endtask

  task automatic send_random_run(input int unsigned count);
    int unsigned done;
    bit          counted;
    done = 0;
    while (done < count) begin
      send_random_request(counted);
      if (counted) done++;
    end
  endtask

  // drop valid, let every owed strobe arrive, then give ignored requests time to clear
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_strobes.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_row_base(input hlcd_pkg::reg_idx_e idx, input logic [6:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    row_base[idx] = value;
    config_writes++;
  endtask

  task automatic write_all_bases(input logic [6:0] b1, input logic [6:0] b2,
                                 input logic [6:0] b3, input logic [6:0] b4);
    write_row_base(hlcd_pkg::RegRow1, b1);
    write_row_base(hlcd_pkg::RegRow2, b2);
    write_row_base(hlcd_pkg::RegRow3, b3);
    write_row_base(hlcd_pkg::RegRow4, b4);
  endtask

  // every request kind and field extreme, with the reset row bases
  task automatic test_directed_requests();
    send_request(hlcd_pkg::CmdInit, 8'h00, 3'd0, 7'd0);
    send_request(hlcd_pkg::CmdByte, 8'h00, 3'd7, 7'd127);
    send_request(hlcd_pkg::CmdByte, 8'hFF, 3'd0, 7'd0);
    send_request(hlcd_pkg::CmdChar, 8'h00, 3'd0, 7'd0);
    send_request(hlcd_pkg::CmdChar, 8'hFF, 3'd7, 7'd127);
    for (int r = 0; r < 8; r++) begin
      send_request(hlcd_pkg::CmdCursor, 8'hA5, 3'(r), (r % 2 == 0) ? 7'd127 : 7'd0);
    end
    send_request(hlcd_pkg::CmdClear, 8'h5A, 3'd0, 7'd0);
    for (int k = CmdUnknownLo; k <= CmdUnknownHi; k++) begin
      send_request(3'(k), 8'hFF, 3'd7, 7'd127);
    end
    wait_drained();
  endtask

  // row bases at both extremes; all-max with max column carries the address sum into bit 7
  task automatic test_row_base_extremes();
    write_all_bases(BaseMax, BaseMax, BaseMax, BaseMax);
    for (int r = hlcd_pkg::Row1; r <= hlcd_pkg::Row4; r++) begin
      send_request(hlcd_pkg::CmdCursor, 8'h00, 3'(r), 7'd127);
      send_request(hlcd_pkg::CmdCursor, 8'h00, 3'(r), 7'd0);
    end
    wait_drained();
    write_all_bases(7'd0, 7'd0, 7'd0, 7'd0);
    for (int r = hlcd_pkg::Row1; r <= hlcd_pkg::Row4; r++) begin
      send_request(hlcd_pkg::CmdCursor, 8'h00, 3'(r), 7'd127);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      write_all_bases(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      send_random_run(62);
      wait_drained();
    end
  endtask

  // sink holds off long enough for the job queue to fill and stall requests
  task automatic test_sink_holdoff();
    sink_holdoff = HoldOffCycles;
    send_random_run(16);
    wait_drained();
  endtask

  task automatic test_full_rate();
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    write_all_bases(hlcd_pkg::Row1Reset, hlcd_pkg::Row2Reset, hlcd_pkg::Row3Reset,
                    hlcd_pkg::Row4Reset);
    send_random_run(40);
    wait_drained();
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = hlcd_pkg::RegRow1;
    cfg_data_i       = 7'd0;
    req_if.valid     = 1'b0;
    req_if.cmd       = hlcd_pkg::CmdInit;
    req_if.data_byte = 8'd0;
    req_if.row       = 3'd0;
    req_if.column    = 7'd0;
    row_base[hlcd_pkg::RegRow1] = hlcd_pkg::Row1Reset;
    row_base[hlcd_pkg::RegRow2] = hlcd_pkg::Row2Reset;
    row_base[hlcd_pkg::RegRow3] = hlcd_pkg::Row3Reset;
    row_base[hlcd_pkg::RegRow4] = hlcd_pkg::Row4Reset;
    error_count     = 0;
    requests_sent   = 0;
    strobes_checked = 0;
    config_writes   = 0;
    sender_gaps_on  = 1'b1;
    sink_stalls_on  = 1'b1;
    sink_holdoff    = 0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_requests();
    test_row_base_extremes();
    test_random_phases();
    test_sink_holdoff();
    test_full_rate();

    if (pending_strobes.size() != 0) begin
      $display("%0t ns: strobes still owed: expected 0 actual %0d", $time,
               pending_strobes.size());
      error_count++;
    end
    $display("ran %0d requests over %0d row base writes, checked %0d strobes",
             requests_sent, config_writes, strobes_checked);
    $display("including init, all row values, base extremes and a long sink hold-off");
    if (error_count == 0) begin
      $display("char_lcd_4bit_write_sequencer: match");
    end else begin
      $display("char_lcd_4bit_write_sequencer: mismatch");
    end
    $finish;
  end

endmodule
